FILE: rtl/lchs_pkg.sv
// Package for the lane column histogram steering core.
// Shared field widths, item layouts, register indexes, reset values and states.
// No dependencies.
package lchs_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int MAX_WIDTH_D  = 512;
  localparam int MAX_HEIGHT_D = 256;
  localparam int COUNT_BITS_D = 8;

  // Field widths
  localparam int GRAY_W  = 8;
  localparam int ROW_W   = 8;
  localparam int COL_W   = 9;
  localparam int POS_W   = 10;
  localparam int PEAK_W  = 8;
  localparam int DEV_W   = 11;
  localparam int THR_W   = 7;
  localparam int LIM_W   = 10;
  localparam int AWID_W  = 10;
  localparam int CTR_W   = 9;

  // Input item layout: gray, pixel_row, pixel_column (edge flag in tuser)
  localparam int IN_DATA_W   = 32;
  localparam int IN_GRAY_LSB = 0;
  localparam int IN_ROW_LSB  = 8;
  localparam int IN_COL_LSB  = 16;

  // Result item layout: lane_position, peak_count, deviation, left, right
  localparam int OUT_DATA_W    = 48;
  localparam int OUT_POS_LSB   = 0;
  localparam int OUT_PEAK_LSB  = 10;
  localparam int OUT_DEV_LSB   = 18;
  localparam int OUT_LEFT_LSB  = 29;
  localparam int OUT_RIGHT_LSB = 36;
  localparam int OUT_PAD_W     = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_LOW,
    REG_BAND_HIGH,
    REG_WIN_FIRST,
    REG_WIN_LAST,
    REG_POS_OFFSET,
    REG_CENTER_COL,
    REG_LOST_LIMIT,
    REG_ACTIVE_WIDTH
  } cfg_reg_t;

  // Register reset values
  localparam logic [GRAY_W-1:0] RST_BAND_LOW     = 8'd5;
  localparam logic [GRAY_W-1:0] RST_BAND_HIGH    = 8'd50;
  localparam logic [ROW_W-1:0]  RST_WIN_FIRST    = 8'd140;
  localparam logic [ROW_W-1:0]  RST_WIN_LAST     = 8'd239;
  localparam logic [7:0]        RST_POS_OFFSET   = 8'd16;
  localparam logic [CTR_W-1:0]  RST_CENTER_COL   = 9'd180;
  localparam logic [LIM_W-1:0]  RST_LOST_LIMIT   = 10'd140;
  localparam logic [AWID_W-1:0] RST_ACTIVE_WIDTH = 10'd360;

  // Thrust codes in percent
  localparam logic [THR_W-1:0] THRUST_OFF  = 7'd0;
  localparam logic [THR_W-1:0] THRUST_LOW  = 7'd20;
  localparam logic [THR_W-1:0] THRUST_HIGH = 7'd50;

  localparam logic [POS_W-1:0]  POS_MAX  = '1;
  localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_TAIL,
    ST_POS,
    ST_CALC,
    ST_PUSH
  } state_t;

endpackage

FILE: rtl/lane_column_histogram_steer_core.sv
// Lane column histogram steering core: per-column hit counters in one memory,
// a sweep sequencer for peak search and clearing, and the steering result.
// Depends on lchs_pkg.
//
// Sequencing: a pixel item is accepted, then its counter is read-modify-written
// through the single memory port before the next pixel is taken. A frame_end
// item adds a sweep over the counter memory, then tail compare, position,
// deviation and output load, which waits while the last result is stalled.
// Reset: synchronous, active low; afterwards a clearing pass over the counter
// memory zeroes the counters with in_tready low. Config writes are always taken.
module lane_column_histogram_steer_core #(
  parameter int MAX_WIDTH  = lchs_pkg::MAX_WIDTH_D,
  parameter int MAX_HEIGHT = lchs_pkg::MAX_HEIGHT_D,
  parameter int COUNT_BITS = lchs_pkg::COUNT_BITS_D
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: gray [7:0], pixel_row [15:8], pixel_column [24:16], zeros above
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lchs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,   // edge_req
  input  logic                            in_tlast,   // frame_end
  // out_tdata: lane_position [9:0], peak_count [17:10], deviation [28:18],
  //            left_thrust [35:29], right_thrust [42:36], zeros above
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lchs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser,  // lane_lost
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lchs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lchs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lchs_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int SW  = AW + 1;
  localparam int WBC = $clog2(MAX_WIDTH + 1);
  localparam int WB  = (WBC > AWID_W) ? WBC : AWID_W;
  localparam int HBC = $clog2(MAX_HEIGHT + 1);
  localparam int HB  = (HBC > ROW_W) ? HBC : ROW_W;
  localparam int CW  = (AW > COL_W) ? AW : COL_W;
  localparam int SB  = ((AW > COL_W) ? AW : COL_W) + 1;
  localparam int PB  = (COUNT_BITS > PEAK_W) ? COUNT_BITS : PEAK_W;
  localparam logic [SW-1:0]         SWEEP_LAST = SW'(MAX_WIDTH - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;

  // Configuration registers
  logic [GRAY_W-1:0]  band_low_r, band_high_r;
  logic [ROW_W-1:0]   win_first_r, win_last_r;
  logic [7:0]         pos_offset_r;
  logic [CTR_W-1:0]   center_col_r;
  logic [LIM_W-1:0]   lost_limit_r;
  logic [AWID_W-1:0]  active_width_r;

  state_t                state_r, state_nxt;
  logic [SW-1:0]         sc_r;
  logic                  hit_r, last_r;
  logic [AW-1:0]         addr_r;
  logic                  cmp_vld_r;
  logic [AW-1:0]         cmp_col_r;
  logic [COUNT_BITS-1:0] peak_r;
  logic [AW-1:0]         peak_col_r;
  logic [POS_W-1:0]      pos_r;
  logic [DEV_W-1:0]      dev_r;
  logic                  lost_r;
  logic [THR_W-1:0]      left_r, right_r;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;

  // Counter memory
  logic [COUNT_BITS-1:0] cnt_mem [MAX_WIDTH];
  logic [COUNT_BITS-1:0] rd_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [COUNT_BITS-1:0] mem_wdata;

  // Input field slices
  logic [GRAY_W-1:0] in_gray;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [CW-1:0]     in_col_ext;
  logic [AW-1:0]     in_addr;
  logic [WB-1:0]     width_eff;
  logic              in_mark, in_hit;

  assign in_gray    = in_tdata[IN_GRAY_LSB +: GRAY_W];
  assign in_row     = in_tdata[IN_ROW_LSB +: ROW_W];
  assign in_col     = in_tdata[IN_COL_LSB +: COL_W];
  assign in_col_ext = CW'(in_col);
  assign in_addr    = in_col_ext[AW-1:0];

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r     <= RST_BAND_LOW;
      band_high_r    <= RST_BAND_HIGH;
      win_first_r    <= RST_WIN_FIRST;
      win_last_r     <= RST_WIN_LAST;
      pos_offset_r   <= RST_POS_OFFSET;
      center_col_r   <= RST_CENTER_COL;
      lost_limit_r   <= RST_LOST_LIMIT;
      active_width_r <= RST_ACTIVE_WIDTH;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BAND_LOW:     band_low_r     <= cfg_data[GRAY_W-1:0];
        REG_BAND_HIGH:    band_high_r    <= cfg_data[GRAY_W-1:0];
        REG_WIN_FIRST:    win_first_r    <= cfg_data[ROW_W-1:0];
        REG_WIN_LAST:     win_last_r     <= cfg_data[ROW_W-1:0];
        REG_POS_OFFSET:   pos_offset_r   <= cfg_data[7:0];
        REG_CENTER_COL:   center_col_r   <= cfg_data[CTR_W-1:0];
        REG_LOST_LIMIT:   lost_limit_r   <= cfg_data[LIM_W-1:0];
        REG_ACTIVE_WIDTH: active_width_r <= cfg_data[AWID_W-1:0];
      endcase
    end
  end

  // Effective width: zero reads as one, clipped to the counter depth
  always_comb begin
    priority if (active_width_r == '0) begin
      width_eff = WB'(1);
    end else if (WB'(active_width_r) > WB'(MAX_WIDTH)) begin
      width_eff = WB'(MAX_WIDTH);
    end else begin
      width_eff = WB'(active_width_r);
    end
  end

  // Pixel marking and window test
  assign in_mark = ((in_gray >= band_low_r) && (in_gray <= band_high_r)) || in_tuser;
  assign in_hit  = in_mark && (in_row >= win_first_r) && (in_row <= win_last_r) &&
                   (HB'(in_row) < HB'(MAX_HEIGHT)) && (WB'(in_col) < width_eff);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sc_r == SWEEP_LAST) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_COUNT;
      ST_COUNT: state_nxt = last_r ? ST_SCAN : ST_IDLE;
      ST_SCAN:  if (sc_r == SWEEP_LAST) state_nxt = ST_TAIL;
      ST_TAIL:  state_nxt = ST_POS;
      ST_POS:   state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_PUSH;
      ST_PUSH:  if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and memory port
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = sc_r[AW-1:0];
    mem_wdata = '0;
    unique case (state_r)
      ST_CLEAR, ST_SCAN: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_addr  = in_addr;
      end
      ST_COUNT: begin
        mem_we    = hit_r;
        mem_addr  = addr_r;
        mem_wdata = (rd_q == CNT_MAX) ? rd_q : rd_q + 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Memory: one write, one registered read (old data on a same-address write)
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_addr] <= mem_wdata;
    end
    rd_q <= cnt_mem[mem_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      sc_r      <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == ST_SCAN);
      if ((state_r == ST_CLEAR) || (state_r == ST_SCAN)) begin
        sc_r <= (sc_r == SWEEP_LAST) ? '0 : sc_r + 1'b1;
      end
    end
  end

  // Accepted pixel
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hit_r  <= in_hit;
      last_r <= in_tlast;
      addr_r <= in_addr;
    end
    cmp_col_r <= sc_r[AW-1:0];
  end

  // Peak search: strict compare keeps the first column with the top count
  always_ff @(posedge clk) begin
    if (state_r == ST_COUNT) begin
      peak_r     <= '0;
      peak_col_r <= '0;
    end else if (cmp_vld_r && (WB'(cmp_col_r) < width_eff) && (rd_q > peak_r)) begin
      peak_r     <= rd_q;
      peak_col_r <= cmp_col_r;
    end
  end

  // Lane position, deviation and thrust
  logic [SB-1:0]           pos_sum;
  logic signed [DEV_W-1:0] dev_s;
  logic [DEV_W-1:0]        dev_mag;
  logic                    lost_c;
  logic [PB-1:0]           peak_ext;
  logic [PEAK_W-1:0]       peak_out;

  assign pos_sum  = SB'(peak_col_r) + SB'(pos_offset_r);
  assign dev_s    = $signed(DEV_W'(pos_r)) - $signed(DEV_W'(center_col_r));
  assign dev_mag  = dev_s[DEV_W-1] ? DEV_W'(-dev_s) : DEV_W'(dev_s);
  assign lost_c   = dev_mag > DEV_W'(lost_limit_r);
  assign peak_ext = PB'(peak_r);
  assign peak_out = (peak_ext > PB'(PEAK_MAX)) ? PEAK_MAX : peak_ext[PEAK_W-1:0];

  always_ff @(posedge clk) begin
    if (state_r == ST_POS) begin
      pos_r <= (pos_sum > SB'(POS_MAX)) ? POS_MAX : pos_sum[POS_W-1:0];
    end
    if (state_r == ST_CALC) begin
      dev_r  <= dev_s;
      lost_r <= lost_c;
      priority if (lost_c) begin
        left_r  <= THRUST_OFF;
        right_r <= THRUST_OFF;
      end else if (dev_s < 0) begin
        left_r  <= THRUST_LOW;
        right_r <= THRUST_HIGH;
      end else if (dev_s > 0) begin
        left_r  <= THRUST_HIGH;
        right_r <= THRUST_LOW;
      end else begin
        left_r  <= THRUST_HIGH;
        right_r <= THRUST_HIGH;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == ST_PUSH) && (!out_tvalid_r || out_tready)) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_PUSH) && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, right_r, left_r, dev_r, peak_out, pos_r};
      out_tuser_r <= lost_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

FILE: rtl/lchs_checker.sv
// Port-level checker for the lane column histogram steering core, with bind.
// Depends on lchs_pkg and lane_column_histogram_steer_core.
module lchs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lchs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import lchs_pkg::*;

  // Reset leaves no result and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("result or ready after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Each item needs its counter update before the next is taken
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken during counter update");

  // Lost lane stops both motors
  a_lost_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[OUT_LEFT_LSB +: THR_W] == THRUST_OFF &&
      out_tdata[OUT_RIGHT_LSB +: THR_W] == THRUST_OFF)
    else $error("thrust while lane lost");

  // Zero deviation drives straight ahead
  a_straight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && out_tdata[OUT_DEV_LSB +: DEV_W] == '0 |->
      out_tdata[OUT_LEFT_LSB +: THR_W] == THRUST_HIGH &&
      out_tdata[OUT_RIGHT_LSB +: THR_W] == THRUST_HIGH)
    else $error("zero deviation not straight");

endmodule

bind lane_column_histogram_steer_core lchs_checker u_lchs_checker (.*);
